@@ sv/kmcf_pkg.sv @@
// Package for the keyboard make-code FIFO.
// Request and status codes, field widths, controller/datapath structs and the
// scan code set 1 to ASCII table. No dependencies.
package kmcf_pkg;

  // default ring depth (one slot always kept free)
  localparam int DEPTH_DEF = 256;

  localparam int REQ_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int STAT_W  = 3;
  localparam int CODE_W  = 7;
  localparam int COUNT_W = 32;

  // packed beat widths
  localparam int IN_DATA_W  = 8;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 3;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_ARRIVAL = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP_RAW = 2'd1;
  localparam logic [REQ_W-1:0] REQ_POP_ASC = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_STORED = 3'd0;
  localparam logic [STAT_W-1:0] ST_BREAK  = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 3'd2;
  localparam logic [STAT_W-1:0] ST_POPPED = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd4;

  // only codes below this can have a table entry
  localparam logic [CODE_W-1:0] MAP_SIZE = 7'd59;

  // controller commands to the datapath
  typedef struct packed {
    logic capture;  // latch the accepted request
    logic exec;     // update pointers, count, store
    logic emit;     // load the output register
  } kmcf_cmd_t;

  // datapath status back to the controller
  typedef struct packed {
    logic slot_free;  // output register can take a result this cycle
  } kmcf_stat_t;

  // scan code set 1 make code to ASCII, 0 where unmapped
  function automatic logic [CODE_W-1:0] scan_to_ascii(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] ch;
    case (code)
      7'd2:    ch = 7'h31;
      7'd3:    ch = 7'h32;
      7'd4:    ch = 7'h33;
      7'd5:    ch = 7'h34;
      7'd6:    ch = 7'h35;
      7'd7:    ch = 7'h36;
      7'd8:    ch = 7'h37;
      7'd9:    ch = 7'h38;
      7'd10:   ch = 7'h39;
      7'd11:   ch = 7'h30;
      7'd12:   ch = 7'h2D;
      7'd13:   ch = 7'h3D;
      7'd16:   ch = 7'h71;
      7'd17:   ch = 7'h77;
      7'd18:   ch = 7'h65;
      7'd19:   ch = 7'h72;
      7'd20:   ch = 7'h74;
      7'd21:   ch = 7'h79;
      7'd22:   ch = 7'h75;
      7'd23:   ch = 7'h69;
      7'd24:   ch = 7'h6F;
      7'd25:   ch = 7'h70;
      7'd26:   ch = 7'h5B;
      7'd27:   ch = 7'h5D;
      7'd28:   ch = 7'h0A;  // enter gives newline
      7'd30:   ch = 7'h61;
      7'd31:   ch = 7'h73;
      7'd32:   ch = 7'h64;
      7'd33:   ch = 7'h66;
      7'd34:   ch = 7'h67;
      7'd35:   ch = 7'h68;
      7'd36:   ch = 7'h6A;
      7'd37:   ch = 7'h6B;
      7'd38:   ch = 7'h6C;
      7'd39:   ch = 7'h3B;
      7'd40:   ch = 7'h27;
      7'd41:   ch = 7'h60;
      7'd43:   ch = 7'h5C;
      7'd44:   ch = 7'h7A;
      7'd45:   ch = 7'h78;
      7'd46:   ch = 7'h63;
      7'd47:   ch = 7'h76;
      7'd48:   ch = 7'h62;
      7'd49:   ch = 7'h6E;
      7'd50:   ch = 7'h6D;
      7'd51:   ch = 7'h2C;
      7'd52:   ch = 7'h2E;
      7'd53:   ch = 7'h2F;
      7'd57:   ch = 7'h20;  // space bar
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

endpackage

@@ sv/kmcf_ctrl.sv @@
// Sequencing controller for the keyboard make-code FIFO.
// One-hot FSM: accept, execute, emit. Depends on kmcf_pkg.
module kmcf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  kmcf_pkg::kmcf_stat_t st,
  output kmcf_pkg::kmcf_cmd_t  cmd
);
  import kmcf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    cmd.emit    = 1'b0;
    in_tready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // hold until the output register has room
        if (st.slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ sv/kmcf_dp.sv @@
// Datapath for the keyboard make-code FIFO: ring store, pointers,
// arrival count and output register. Depends on kmcf_pkg.
module kmcf_dp #(
  parameter int DEPTH = kmcf_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  kmcf_pkg::kmcf_cmd_t                 cmd,
  output kmcf_pkg::kmcf_stat_t                st,
  input  logic [kmcf_pkg::REQ_W-1:0]          req_type,
  input  logic [kmcf_pkg::BYTE_W-1:0]         scan_byte,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [kmcf_pkg::STAT_W-1:0]         status,
  output logic [kmcf_pkg::CODE_W-1:0]         code_out,
  output logic [kmcf_pkg::CODE_W-1:0]         ascii_out,
  output logic [kmcf_pkg::COUNT_W-1:0]        arrival_count
);
  import kmcf_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [CODE_W-1:0]  mem [DEPTH];
  logic [AW-1:0]      rd_ptr_r, wr_ptr_r;
  logic [AW-1:0]      rd_ptr_inc, wr_ptr_inc;
  logic [COUNT_W-1:0] count_r;
  logic [REQ_W-1:0]   req_r;
  logic [BYTE_W-1:0]  byte_r;
  logic [STAT_W-1:0]  stat_r;
  logic               popped_r, xlat_r;
  logic [CODE_W-1:0]  rd_data_r;
  logic               out_valid_r;
  logic [STAT_W-1:0]  out_stat_r;
  logic [CODE_W-1:0]  out_code_r, out_ascii_r;
  logic [COUNT_W-1:0] out_count_r;

  logic is_arr, is_pop, is_brk, full, empty, do_wr, do_rd;
  logic [CODE_W-1:0] code_sel;

  // wrapping pointer increments
  assign rd_ptr_inc = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
  assign wr_ptr_inc = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;

  // request decode against ring state
  assign is_arr = (req_r == REQ_ARRIVAL);
  assign is_pop = (req_r == REQ_POP_RAW) || (req_r == REQ_POP_ASC);
  assign is_brk = byte_r[BYTE_W-1];
  assign full   = (wr_ptr_inc == rd_ptr_r);
  assign empty  = (rd_ptr_r == wr_ptr_r);
  assign do_wr  = cmd.exec && is_arr && !is_brk && !full;
  assign do_rd  = cmd.exec && is_pop && !empty;

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= req_type;
      byte_r <= scan_byte;
    end
  end

  // pointers and arrival count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_inc;
      if (do_rd) rd_ptr_r <= rd_ptr_inc;
      if (cmd.exec && is_arr) count_r <= count_r + 1'b1;
    end
  end

  // code store, registered read
  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr_r] <= byte_r[CODE_W-1:0];
    if (do_rd) rd_data_r <= mem[rd_ptr_r];
  end

  // result status for the emit step
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      popped_r <= do_rd;
      xlat_r   <= (req_r == REQ_POP_ASC);
      if (is_arr) begin
        stat_r <= is_brk ? ST_BREAK : (full ? ST_FULL : ST_STORED);
      end else begin
        stat_r <= do_rd ? ST_POPPED : ST_EMPTY;
      end
    end
  end

  assign code_sel = popped_r ? rd_data_r : '0;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_stat_r  <= stat_r;
      out_code_r  <= code_sel;
      out_ascii_r <= (popped_r && xlat_r && (code_sel < MAP_SIZE)) ?
                     scan_to_ascii(code_sel) : '0;
      out_count_r <= count_r;
    end
  end

  assign st.slot_free   = !out_valid_r || out_tready;
  assign out_tvalid     = out_valid_r;
  assign status         = out_stat_r;
  assign code_out       = out_code_r;
  assign ascii_out      = out_ascii_r;
  assign arrival_count  = out_count_r;

endmodule

@@ sv/keyboard_make_code_fifo.sv @@
// Top level of the keyboard make-code FIFO.
// Joins kmcf_ctrl and kmcf_dp; depends on kmcf_pkg.
//
// Keyboard receive buffer for scan code set 1. Each input beat is an arrival
// (scancode byte), a raw pop, or a pop with ASCII translation, and gives
// exactly one result beat. Arrivals always bump a wrapping 32-bit count;
// break codes are reported and dropped; make codes enter a ring of DEPTH
// slots that holds at most DEPTH-1 codes, and a full ring drops the code.
// Each request passes capture, execute with the store access, and emit, in
// that order, before its result is in the output register; emit waits while
// the output register holds an undrained result, and no new beat is taken
// until the emit. The registered read of the code store sets that sequence.
// The output register lets the next request be accepted while a result still waits.
module keyboard_make_code_fifo #(
  parameter int DEPTH = kmcf_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [kmcf_pkg::IN_DATA_W-1:0]     in_tdata,   // [7:0] scan_byte
  input  logic [kmcf_pkg::IN_USER_W-1:0]     in_tuser,   // [1:0] req_type
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [6:0] code_out, [13:7] ascii_out, [45:14] arrival_count, [47:46] zero
  output logic [kmcf_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [kmcf_pkg::OUT_USER_W-1:0]    out_tuser   // [2:0] status
);
  import kmcf_pkg::*;

  kmcf_cmd_t  cmd;
  kmcf_stat_t st;
  logic [STAT_W-1:0]  status;
  logic [CODE_W-1:0]  code_out, ascii_out;
  logic [COUNT_W-1:0] arrival_count;

  kmcf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  kmcf_dp #(.DEPTH(DEPTH)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .req_type      (in_tuser[REQ_W-1:0]),
    .scan_byte     (in_tdata[BYTE_W-1:0]),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .status        (status),
    .code_out      (code_out),
    .ascii_out     (ascii_out),
    .arrival_count (arrival_count)
  );

  // pack result beat
  assign out_tdata = {2'b00, arrival_count, ascii_out, code_out};
  assign out_tuser = status;

endmodule

@@ sv/kmcf_checker.sv @@
// Port-level checks for keyboard_make_code_fifo, bound to the top level.
// Depends on kmcf_pkg.
module kmcf_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [kmcf_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [kmcf_pkg::OUT_USER_W-1:0] out_tuser
);
  import kmcf_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // one request in flight: no accept straight after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request accepted while one is in flight");

  // only a pop that returned a code carries code or character
  a_no_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_POPPED) |-> (out_tdata[13:0] == 14'd0))
    else $error("code data on a result with nothing popped");

  // padding bits stay clear
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[47:46] == 2'b00))
    else $error("padding bits set in result beat");

endmodule

bind keyboard_make_code_fifo kmcf_checker u_kmcf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
